FILE: rtl/pcgo_pkg.sv
// ----------------------------------------------------------------------------
// pcgo_pkg
// Shared types and constants for the point cloud grid overlap block.
// ----------------------------------------------------------------------------
package pcgo_pkg;

    localparam int GRID_SIDE_DEF = 16;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_LOW   = 3'd1;
    localparam logic [2:0] CMD_HIGH  = 3'd2;
    localparam logic [2:0] CMD_POINT = 3'd3;
    localparam logic [2:0] CMD_EVAL  = 3'd4;

    localparam logic [1:0] REG_INV_X = 2'd0;
    localparam logic [1:0] REG_INV_Y = 2'd1;
    localparam logic [1:0] REG_INV_Z = 2'd2;

    // classified item handed from front to back
    typedef struct packed {
        logic [2:0]  cmd;
        logic        bubble;
        logic [47:0] gx;
        logic [47:0] gy;
        logic [47:0] gz;
    } job_t;

    // signed 64-bit product, floor or ceil of Q32.32 to 32.0
    function automatic logic signed [31:0] round_q32(input logic signed [63:0] p,
                                                     input logic up);
        logic signed [31:0] f;
        begin
            f = p[63:32];
            if (up && (p[31:0] != 32'd0))
                f = f + 32'sd1;
            round_q32 = f;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        begin
            if (v > 32'sd32767)
                sat16 = 16'sh7fff;
            else if (v < -32'sd32768)
                sat16 = 16'sh8000;
            else
                sat16 = v[15:0];
        end
    endfunction

endpackage

FILE: rtl/pcgo_front.sv
// ----------------------------------------------------------------------------
// pcgo_front
// Accepts items, scales the coordinates to grid units, feeds a short queue.
// ----------------------------------------------------------------------------
module pcgo_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          command,
    input  logic                which_bubble,
    input  logic signed [31:0]  x_coord,
    input  logic signed [31:0]  y_coord,
    input  logic signed [31:0]  z_coord,
    input  logic [31:0]         inv_x,
    input  logic [31:0]         inv_y,
    input  logic [31:0]         inv_z,
    output logic                job_valid,
    input  logic                job_ready,
    output pcgo_pkg::job_t      job
);
    import pcgo_pkg::*;

    // stage 1: product registers
    logic               s1_valid_reg;
    logic [2:0]         s1_cmd_reg;
    logic               s1_b_reg;
    logic signed [63:0] s1_px_reg, s1_py_reg, s1_pz_reg;

    // queue, 4 deep
    job_t       q_mem [4];
    logic [2:0] q_cnt_reg, q_cnt_next;
    logic [1:0] q_wr_reg, q_rd_reg;

    logic s1_adv, q_push, q_pop;
    logic up;
    job_t nj;

    assign q_pop     = job_valid && job_ready;
    assign job_valid = (q_cnt_reg != 3'd0);
    assign job       = q_mem[q_rd_reg];
    // room for the stage-1 item plus one more
    assign in_ready  = (q_cnt_reg + {2'd0, s1_valid_reg}) < 3'd4;
    assign s1_adv    = in_valid && in_ready;
    assign q_push    = s1_valid_reg;

    always_comb
    begin
        up     = (s1_cmd_reg == CMD_HIGH);
        nj.cmd = s1_cmd_reg;
        nj.bubble = s1_b_reg;
        nj.gx  = {{16{s1_px_reg[63]}}, round_q32(s1_px_reg, up)};
        nj.gy  = {{16{s1_py_reg[63]}}, round_q32(s1_py_reg, up)};
        nj.gz  = {{16{s1_pz_reg[63]}}, round_q32(s1_pz_reg, up)};
        q_cnt_next = q_cnt_reg + {2'd0, q_push} - {2'd0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            q_cnt_reg    <= 3'd0;
            q_wr_reg     <= 2'd0;
            q_rd_reg     <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= s1_adv;
            q_cnt_reg    <= q_cnt_next;
            if (q_push)
                q_wr_reg <= q_wr_reg + 2'd1;
            if (q_pop)
                q_rd_reg <= q_rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_cmd_reg <= command;
            s1_b_reg   <= which_bubble;
            s1_px_reg  <= x_coord * $signed({1'b0, inv_x});
            s1_py_reg  <= y_coord * $signed({1'b0, inv_y});
            s1_pz_reg  <= z_coord * $signed({1'b0, inv_z});
        end
        if (q_push)
            q_mem[q_wr_reg] <= nj;
    end

endmodule

FILE: rtl/pcgo_back.sv
// ----------------------------------------------------------------------------
// pcgo_back
// Holds boxes, region, occupancy memory and flags; executes queued items.
// ----------------------------------------------------------------------------
module pcgo_back #(
    parameter int GRID_SIDE = pcgo_pkg::GRID_SIDE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_ready,
    input  pcgo_pkg::job_t  job,
    output logic            empty,
    input  logic            pop,
    output logic            boxes_overlap,
    output logic            cells_shared,
    output logic            region_overflow
);
    import pcgo_pkg::*;

    localparam int SW    = $clog2(GRID_SIDE);
    localparam int AW    = 3 * SW;
    localparam int CELLS = 1 << AW;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_RMW   = 2'd2;

    logic [1:0]  state_reg;
    logic [AW:0] clr_reg;

    logic signed [15:0] bb_reg [12];
    logic signed [15:0] org_reg [3];
    logic [15:0]        ext_reg [3];
    logic               region_dirty_reg;
    logic               hit_reg, ovf_reg;

    logic [1:0]    occ [CELLS];
    logic [1:0]    rd_reg;
    logic [AW-1:0] addr_reg;
    logic          bit_b_reg;

    logic          out_full_reg;
    logic          ov_reg, sh_reg, big_reg;

    logic          take;
    logic          pt_in, pt_beyond;
    logic [AW-1:0] pt_addr;
    logic signed [47:0] g [3];
    logic signed [17:0] idx [3];
    logic          touch;
    logic          big;
    logic [3:0]    bb_base;

    assign empty           = !out_full_reg;
    assign boxes_overlap   = ov_reg;
    assign cells_shared    = sh_reg;
    assign region_overflow = big_reg;

    assign job_ready = (state_reg == ST_RUN) && !region_dirty_reg &&
                       !(job.cmd == CMD_EVAL && out_full_reg);
    assign take = job_valid && job_ready;

    function automatic logic rt(input logic signed [15:0] li, input logic signed [15:0] hi,
                                input logic signed [15:0] lj, input logic signed [15:0] hj);
        rt = (hj > li && hj <= hi) || (lj >= li && lj < hi) ||
             (hi > lj && hi <= hj) || (li >= lj && li < hj);
    endfunction

    always_comb
    begin
        g[0] = job.gx;
        g[1] = job.gy;
        g[2] = job.gz;
        bb_base   = (job.bubble ? 4'd6 : 4'd0) + ((job.cmd == CMD_HIGH) ? 4'd3 : 4'd0);
        pt_in     = 1'b1;
        pt_beyond = 1'b0;
        pt_addr   = '0;
        for (int k = 0; k < 3; k++)
        begin
            idx[k] = 18'(g[k][31:0]) - 18'(org_reg[k]);
            if (g[k] - 48'(org_reg[k]) < 0 ||
                g[k] - 48'(org_reg[k]) >= $signed({32'd0, ext_reg[k]}))
                pt_in = 1'b0;
            if (idx[k] >= 18'(GRID_SIDE))
                pt_beyond = 1'b1;
        end
        pt_addr = {idx[0][SW-1:0], idx[1][SW-1:0], idx[2][SW-1:0]};
        touch = 1'b1;
        big   = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (!rt(bb_reg[k], bb_reg[3+k], bb_reg[6+k], bb_reg[9+k]))
                touch = 1'b0;
            if (ext_reg[k] > 16'(GRID_SIDE))
                big = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            region_dirty_reg <= 1'b0;
            hit_reg          <= 1'b0;
            ovf_reg          <= 1'b0;
            out_full_reg     <= 1'b0;
            ov_reg           <= 1'b0;
            sh_reg           <= 1'b0;
            big_reg          <= 1'b0;
            for (int i = 0; i < 12; i++)
                bb_reg[i] <= '0;
            for (int k = 0; k < 3; k++)
            begin
                org_reg[k] <= '0;
                ext_reg[k] <= '0;
            end
        end
        else
        begin
            if (pop && out_full_reg)
                out_full_reg <= 1'b0;
            if (region_dirty_reg)
            begin
                region_dirty_reg <= 1'b0;
                for (int k = 0; k < 3; k++)
                begin
                    logic signed [16:0] sa, sb, e;
                    logic signed [15:0] lo, hi;
                    sa = 17'(bb_reg[k]) + 17'(bb_reg[3+k]);
                    sb = 17'(bb_reg[6+k]) + 17'(bb_reg[9+k]);
                    if (sa < sb)
                    begin
                        lo = bb_reg[6+k];
                        hi = bb_reg[3+k];
                    end
                    else
                    begin
                        lo = bb_reg[k];
                        hi = bb_reg[9+k];
                    end
                    e = 17'(hi) - 17'(lo);
                    org_reg[k] <= lo;
                    ext_reg[k] <= (e < 0) ? 16'd0 : e[15:0];
                end
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(CELLS - 1))
                        state_reg <= ST_RUN;
                end
                ST_RMW:
                begin
                    if (rd_reg[bit_b_reg ? 0 : 1])
                        hit_reg <= 1'b1;
                    state_reg <= ST_RUN;
                end
                default:
                begin
                    if (take)
                    begin
                        unique case (job.cmd)
                            CMD_START:
                            begin
                                hit_reg   <= 1'b0;
                                ovf_reg   <= 1'b0;
                                clr_reg   <= '0;
                                state_reg <= ST_CLEAR;
                            end
                            CMD_LOW, CMD_HIGH:
                            begin
                                bb_reg[bb_base]        <= sat16(job.gx[31:0]);
                                bb_reg[bb_base + 4'd1] <= sat16(job.gy[31:0]);
                                bb_reg[bb_base + 4'd2] <= sat16(job.gz[31:0]);
                                region_dirty_reg <= 1'b1;
                            end
                            CMD_POINT:
                            begin
                                if (pt_in && pt_beyond)
                                    ovf_reg <= 1'b1;
                                else if (pt_in)
                                    state_reg <= ST_RMW;
                            end
                            CMD_EVAL:
                            begin
                                out_full_reg <= 1'b1;
                                ov_reg  <= touch;
                                sh_reg  <= touch && hit_reg;
                                big_reg <= ovf_reg || (touch && big);
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // occupancy memory: clear sweep, read then write-back
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            occ[clr_reg[AW-1:0]] <= 2'b00;
        else if (state_reg == ST_RMW)
            occ[addr_reg] <= rd_reg | (bit_b_reg ? 2'b10 : 2'b01);
        rd_reg <= occ[pt_addr];
        if (take)
        begin
            addr_reg  <= pt_addr;
            bit_b_reg <= job.bubble;
        end
    end

endmodule

FILE: rtl/point_cloud_grid_overlap.sv
// ----------------------------------------------------------------------------
// point_cloud_grid_overlap
// Tests two point clouds for contact via box overlap and an occupancy grid.
// ----------------------------------------------------------------------------
// Input channel: push/full with command, which_bubble and coordinates.
// Result channel: empty/pop; only evaluate items give a result.
// Registers inv_cell_x/y/z sit on an APB port at 0x0, 0x4, 0x8; pready is high.
// The front multiplies each coordinate by its register and rounds to grid
// units; a four-entry queue feeds the back, which updates boxes, region and the
// occupancy memory. A point passes a memory read and then a write-back, a
// corner write a region refresh, and evaluate and start no extra step; start
// then runs a clearing pass over every grid cell. An evaluate result is
// registered on the ports as the back takes its item. After reset the same
// clearing pass runs before items flow. A stalled result holds the next
// evaluate at the head of the queue; items behind it wait, and full rises
// once the queue and front stage fill.
// ----------------------------------------------------------------------------
module point_cloud_grid_overlap #(
    parameter int GRID_SIDE = pcgo_pkg::GRID_SIDE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         command,
    input  logic               which_bubble,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic signed [31:0] z_coord,
    output logic               empty,
    input  logic               pop,
    output logic               boxes_overlap,
    output logic               cells_shared,
    output logic               region_overflow,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pcgo_pkg::*;

    logic [31:0] inv_x_reg, inv_y_reg, inv_z_reg;
    logic        in_ready, job_valid, job_ready;
    job_t        job;

    assign pready = 1'b1;
    assign full   = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_x_reg <= 32'd65536;
            inv_y_reg <= 32'd65536;
            inv_z_reg <= 32'd65536;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                REG_INV_X: inv_x_reg <= pwdata;
                REG_INV_Y: inv_y_reg <= pwdata;
                REG_INV_Z: inv_z_reg <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_INV_X: prdata = inv_x_reg;
            REG_INV_Y: prdata = inv_y_reg;
            REG_INV_Z: prdata = inv_z_reg;
            default:   prdata = 32'd0;
        endcase
    end

    pcgo_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (push),
        .in_ready     (in_ready),
        .command      (command),
        .which_bubble (which_bubble),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .z_coord      (z_coord),
        .inv_x        (inv_x_reg),
        .inv_y        (inv_y_reg),
        .inv_z        (inv_z_reg),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job)
    );

    pcgo_back #(.GRID_SIDE(GRID_SIDE)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (job_valid),
        .job_ready       (job_ready),
        .job             (job),
        .empty           (empty),
        .pop             (pop),
        .boxes_overlap   (boxes_overlap),
        .cells_shared    (cells_shared),
        .region_overflow (region_overflow)
    );

endmodule

FILE: tb/sv/tb_point_cloud_grid_overlap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_cloud_grid_overlap
// Drives command items into the overlap tester and checks each evaluate
// result against a cycle-free predictor of boxes, region, grid and flags.
// ----------------------------------------------------------------------------
module tb_point_cloud_grid_overlap;
    import pcgo_pkg::*;

    localparam int GS = GRID_SIDE_DEF;
    localparam int WDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [2:0] command = CMD_START;
    logic which_bubble = 1'b0;
    logic signed [31:0] x_coord = '0, y_coord = '0, z_coord = '0;
    logic empty;
    logic pop = 1'b0;
    logic boxes_overlap, cells_shared, region_overflow;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    point_cloud_grid_overlap u_dut (.*);

    initial forever #1 clk = ~clk;

    // predictor state
    logic [31:0] inv_cell [3];
    int box_bounds [12];
    int region_org [3];
    int region_ext [3];
    logic [1:0] grid_bits [GS*GS*GS];
    bit hit_flag, ovf_flag;

    typedef struct packed { logic ov; logic sh; logic rf; } verdict_t;
    verdict_t verdicts [$];

    int errors = 0;
    int idle_cnt = 0;
    int rx_hold = 0;
    bit rx_idle = 1'b1;
    bit settling = 1'b0;

    function automatic longint floor_q(longint p);
        return p >>> 32;
    endfunction

    function automatic longint ceil_q(longint p);
        return -((-p) >>> 32);
    endfunction

    function automatic int clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic bit span_touch(int li, int hi, int lj, int hj);
        return (hj > li && hj <= hi) || (lj >= li && lj < hi) ||
               (hi > lj && hi <= hj) || (li >= lj && li < hj);
    endfunction

    task automatic refresh_region();
        int lo, hi, e;
        for (int k = 0; k < 3; k++)
        begin
            if (box_bounds[k] + box_bounds[3+k] < box_bounds[6+k] + box_bounds[9+k])
            begin
                lo = box_bounds[6+k]; hi = box_bounds[3+k];
            end
            else
            begin
                lo = box_bounds[k]; hi = box_bounds[9+k];
            end
            e = hi - lo;
            if (e < 0) e = 0;
            if (e > 65535) e = 65535;
            region_org[k] = lo;
            region_ext[k] = e;
        end
    endtask

    task automatic predict_item(logic [2:0] cmd, logic b, logic signed [31:0] c [3]);
        longint sc [3];
        longint idx [3];
        bit beyond, outside, ov, big;
        int cell_idx;
        for (int k = 0; k < 3; k++)
            sc[k] = longint'(c[k]) * longint'({32'd0, inv_cell[k]});
        case (cmd)
            CMD_START:
            begin
                foreach (grid_bits[i]) grid_bits[i] = 2'b00;
                hit_flag = 0; ovf_flag = 0;
            end
            CMD_LOW, CMD_HIGH:
            begin
                for (int k = 0; k < 3; k++)
                    box_bounds[b*6 + (cmd == CMD_HIGH ? 3 : 0) + k] =
                        clamp16(cmd == CMD_LOW ? floor_q(sc[k]) : ceil_q(sc[k]));
                refresh_region();
            end
            CMD_POINT:
            begin
                beyond = 0; outside = 0;
                for (int k = 0; k < 3; k++)
                begin
                    idx[k] = floor_q(sc[k]) - region_org[k];
                    if (idx[k] < 0 || idx[k] >= region_ext[k]) outside = 1;
                    if (idx[k] >= GS) beyond = 1;
                end
                if (!outside)
                begin
                    if (beyond) ovf_flag = 1;
                    else
                    begin
                        cell_idx = int'((idx[0] * GS + idx[1]) * GS + idx[2]);
                        grid_bits[cell_idx][b] = 1'b1;
                        if (grid_bits[cell_idx] == 2'b11) hit_flag = 1;
                    end
                end
            end
            CMD_EVAL:
            begin
                ov = 1; big = 0;
                for (int k = 0; k < 3; k++)
                begin
                    if (!span_touch(box_bounds[k], box_bounds[3+k],
                                    box_bounds[6+k], box_bounds[9+k])) ov = 0;
                    if (region_ext[k] > GS) big = 1;
                end
                verdicts.push_back('{ov, ov && hit_flag, ovf_flag || (ov && big)});
            end
            default: ;
        endcase
    endtask

    bit tx_idle = 1'b1;

    task automatic send_item(logic [2:0] cmd, logic b, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] z);
        logic signed [31:0] c [3];
        c[0] = x; c[1] = y; c[2] = z;
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        push <= 1'b1; command <= cmd; which_bubble <= b;
        x_coord <= x; y_coord <= y; z_coord <= z;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_item(cmd, b, c);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (verdicts.size() != 0) @(posedge clk);
        settling = 1'b1;
        repeat (6 * (GS*GS*GS + 4)) @(posedge clk);
        settling = 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        inv_cell[idx] = val;
    endtask

    task automatic set_scales(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
        write_reg(REG_INV_X, sx);
        write_reg(REG_INV_Y, sy);
        write_reg(REG_INV_Z, sz);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && pop && !empty)
        begin
            if (verdicts.size() == 0)
            begin
                $display("%0t unexpected result %b%b%b", $time,
                         boxes_overlap, cells_shared, region_overflow);
                errors++;
            end
            else
            begin
                v = verdicts.pop_front();
                if (v.ov !== boxes_overlap)
                begin
                    $display("%0t boxes_overlap exp %b got %b", $time, v.ov, boxes_overlap);
                    errors++;
                end
                if (v.sh !== cells_shared)
                begin
                    $display("%0t cells_shared exp %b got %b", $time, v.sh, cells_shared);
                    errors++;
                end
                if (v.rf !== region_overflow)
                begin
                    $display("%0t region_overflow exp %b got %b", $time,
                             v.rf, region_overflow);
                    errors++;
                end
            end
        end
        if (rx_idle && rx_hold == 0 && $urandom_range(0, 7) == 0)
        begin
            rx_hold <= $urandom_range(1, 8);
            pop <= 1'b0;
        end
        else if (rx_idle && rx_hold > 1)
        begin
            rx_hold <= rx_hold - 1;
            pop <= 1'b0;
        end
        else
        begin
            rx_hold <= 0;
            pop <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || psel || settling)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WDOG)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [31:0] rnd_small();
        return $signed($urandom_range(0, 20 << 16)) - (2 << 16);
    endfunction

    task automatic test_directed();
        logic signed [31:0] mx, mn;
        mx = 32'sh7fffffff; mn = 32'sh80000000;
        send_item(CMD_START, 0, 0, 0, 0);
        send_item(CMD_EVAL, 0, 0, 0, 0);
        send_item(CMD_LOW, 0, 0, 0, 0);
        send_item(CMD_HIGH, 0, 8 << 16, 8 << 16, 8 << 16);
        send_item(CMD_LOW, 1, 4 << 16, 4 << 16, 4 << 16);
        send_item(CMD_HIGH, 1, 12 << 16, 12 << 16, 12 << 16);
        send_item(CMD_POINT, 0, 5 << 16, 5 << 16, 5 << 16);
        send_item(CMD_POINT, 1, 32'h58000, 32'h58000, 32'h58000);
        send_item(CMD_POINT, 1, 8 << 16, 5 << 16, 5 << 16);  // on region max
        send_item(CMD_POINT, 0, -1, 5 << 16, 5 << 16);
        send_item(CMD_EVAL, 1, 0, 0, 0);
        send_item(3'd5, 0, 0, 0, 0);
        send_item(3'd6, 1, mx, mn, mx);
        send_item(3'd7, 0, mn, mx, mn);
        send_item(CMD_HIGH, 0, mx, mx, mx);                  // saturate high
        send_item(CMD_LOW, 1, mn, mn, mn);                   // saturate low
        send_item(CMD_POINT, 0, 100 << 16, 100 << 16, 100 << 16);
        send_item(CMD_EVAL, 0, 0, 0, 0);
        send_item(CMD_LOW, 0, 50 << 16, 50 << 16, 50 << 16); // inverted
        send_item(CMD_EVAL, 0, 0, 0, 0);
        send_item(CMD_START, 1, 0, 0, 0);
        send_item(CMD_EVAL, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_scales();
        set_scales(32'hffffffff, 32'd0, 32'h8000);
        send_item(CMD_LOW, 0, -3, 1, 32'h7fffffff);
        send_item(CMD_HIGH, 1, 3, 32'h80000000, -32'sd65536);
        send_item(CMD_POINT, 0, 32'h7fffffff, 0, 2);
        send_item(CMD_EVAL, 0, 0, 0, 0);
        drain();
        set_scales(32'd0, 32'hffffffff, 32'd1);
        send_item(CMD_POINT, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_item(CMD_EVAL, 0, 0, 0, 0);
        drain();
    endtask

    task automatic random_scene(int n);
        logic [2:0] cmd;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3) cmd = CMD_START;
            else if (r < 10) cmd = CMD_LOW;
            else if (r < 17) cmd = CMD_HIGH;
            else if (r < 85) cmd = CMD_POINT;
            else if (r < 97) cmd = CMD_EVAL;
            else cmd = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 19) == 0)
                send_item(cmd, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
            else
                send_item(cmd, 1'($urandom_range(0, 1)), rnd_small(), rnd_small(),
                          rnd_small());
        end
    endtask

    task automatic test_random();
        set_scales(32'h10000, 32'h10000, 32'h10000);
        send_item(CMD_START, 0, 0, 0, 0);
        send_item(CMD_LOW, 0, 0, 0, 0);
        send_item(CMD_HIGH, 0, 10 << 16, 10 << 16, 10 << 16);
        send_item(CMD_LOW, 1, 3 << 16, 3 << 16, 3 << 16);
        send_item(CMD_HIGH, 1, 14 << 16, 14 << 16, 14 << 16);
        random_scene(300);
        drain();
        set_scales(32'h20000, 32'h8000, 32'h18000);
        random_scene(250);
        drain();
        set_scales($urandom, $urandom, $urandom);
        random_scene(60);
        drain();
        set_scales(32'h10000, 32'h10000, 32'h10000);
        tx_idle = 0;
        rx_idle = 0;
        random_scene(200);
    endtask

    initial
    begin
        inv_cell[0] = 32'h10000; inv_cell[1] = 32'h10000; inv_cell[2] = 32'h10000;
        foreach (box_bounds[i]) box_bounds[i] = 0;
        for (int k = 0; k < 3; k++) begin region_org[k] = 0; region_ext[k] = 0; end
        foreach (grid_bits[i]) grid_bits[i] = 2'b00;
        hit_flag = 0; ovf_flag = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_scales();
        test_random();
        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
